### rtl/iplpr_pkg.sv
// Package for the IPv6 longest-prefix route table.
// Types, operation codes and helper functions; no dependencies.
package iplpr_pkg;

	localparam int ROUTE_ENTRIES_DEF = 16;
	localparam int IFACE_COUNT_DEF = 16;
	localparam logic [7:0] HOST_PREFIX = 8'd128;
	localparam logic [31:0] FULL_METRIC = 32'hffff_ffff;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_REMOVE_ROUTE = 3'd1,
		OP_REMOVE_IFACE = 3'd2,
		OP_LOOKUP = 3'd3,
		OP_HAS_DEST = 3'd4
	} op_t;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NO_ROUTE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [63:0] net_hi;
		logic [63:0] net_lo;
		logic [63:0] gw_hi;
		logic [63:0] gw_lo;
		logic [7:0] prefix;
		logic [3:0] iface;
		logic [31:0] metric;
	} route_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [63:0] dest_hi;
		logic [63:0] dest_lo;
		logic [7:0] prefix_len;
		logic [63:0] gateway_hi;
		logic [63:0] gateway_lo;
		logic [3:0] interface_index;
		logic filter_enable;
		logic [31:0] metric;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic found;
		logic [63:0] route_dest_hi;
		logic [63:0] route_dest_lo;
		logic [63:0] route_gateway_hi;
		logic [63:0] route_gateway_lo;
		logic [3:0] route_interface;
		logic [31:0] route_metric;
	} rsp_t;

	function automatic logic prefix_match(input logic [7:0] len,
			input logic [63:0] ahi, input logic [63:0] alo,
			input logic [63:0] bhi, input logic [63:0] blo);
		logic [127:0] mask;
		logic [127:0] diff;
		begin
			mask = (len >= HOST_PREFIX) ? '1 : ~({128{1'b1}} >> len);
			diff = {ahi ^ bhi, alo ^ blo};
			prefix_match = ((diff & mask) == '0);
		end
	endfunction

endpackage

### rtl/iplpr_if.sv
// Valid/ready channel interface carrying one payload beat.
// Depends on nothing; payload type is a parameter.
interface iplpr_if #(parameter type payload_t = logic) (input logic clk);
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/iplpr_cell.sv
// One cell of the route ring: holds one route and its occupancy bit.
// Depends on iplpr_pkg.
module iplpr_cell import iplpr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic shift,
	input logic load,
	input route_t load_route,
	input route_t route_in,
	input logic use_in,
	output route_t route,
	output logic used
);
	route_t route_q;
	logic used_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			route_q <= load ? load_route : route_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (shift) begin
			used_q <= load | use_in;
		end
	end

	assign route = route_q;
	assign used = used_q;
endmodule

### rtl/ipv6_longest_prefix_route_table.sv
// IPv6 longest-prefix route table. Routes sit in a ring of ROUTE_ENTRIES cells that advances
// one place per cycle past a scan point at cell 0; every operation passes each cell through
// once: the beat is accepted, each cell passes the scan point, then the result is posted. A
// result beat still waiting holds the next result. Removed routes drop out as they pass and
// the survivors close up in insertion order; an append lands right behind the last route.
module ipv6_longest_prefix_route_table import iplpr_pkg::*; #(
	parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF,
	parameter int IFACE_COUNT = IFACE_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	iplpr_if.sink req,
	iplpr_if.source rsp
);
	localparam int CW = $clog2(ROUTE_ENTRIES + 1);
	localparam int IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

	state_t state_q, state_d;
	req_t req_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] gap_q;
	logic [IW-1:0] step_q;
	rsp_t rsp_q, rsp_d;
	logic rsp_valid_q;
	logic full_q;

	route_t cell_route [ROUTE_ENTRIES];
	logic cell_used [ROUTE_ENTRIES];
	route_t put_route;
	logic put_c, ins_put, shift_c, done_c, last_c;

	logic hit_q, stop_q;
	logic [7:0] longest_q;
	logic [31:0] shortest_q;
	route_t pick_q;

	logic [7:0] len_c;
	logic is_mc, drop_c, match_c, ins_ok, take_c;
	route_t head;

	assign len_c = (req_q.prefix_len > HOST_PREFIX) ? HOST_PREFIX : req_q.prefix_len;
	assign head = cell_route[0];
	assign is_mc = req_q.dest_hi[63:56] == 8'hff;
	assign ins_ok = ({28'd0, req_q.interface_index} < IFACE_COUNT) &&
		({{(32-CW){1'b0}}, count_q} < ROUTE_ENTRIES);
	assign match_c = cell_used[0] &&
		prefix_match(head.prefix, req_q.dest_hi, req_q.dest_lo, head.net_hi, head.net_lo);
	assign take_c = match_c && !stop_q &&
		(!req_q.filter_enable || head.iface == req_q.interface_index) &&
		head.prefix >= longest_q &&
		(head.prefix > longest_q || head.metric <= shortest_q);

	always_comb begin
		drop_c = 1'b0;
		case (req_q.mode)
			OP_REMOVE_ROUTE: drop_c = head.iface == req_q.interface_index &&
				head.net_hi == req_q.dest_hi && head.net_lo == req_q.dest_lo &&
				head.prefix == len_c;
			OP_REMOVE_IFACE: drop_c = head.iface == req_q.interface_index;
			default: drop_c = 1'b0;
		endcase
	end

	assign shift_c = state_q == S_SCAN;
	assign last_c = step_q == IW'(ROUTE_ENTRIES - 1);
	assign ins_put = last_c && req_q.mode == OP_INSERT && ins_ok && !cell_used[0];
	assign put_c = shift_c && ((cell_used[0] && !drop_c) || ins_put);
	assign done_c = state_q == S_DONE && (!rsp_valid_q || rsp.ready);

	// Kept route lands behind the routes already passed; gap_q counts free slots behind it.
	always_comb begin
		put_route = head;
		if (ins_put) begin
			put_route = '{net_hi: req_q.dest_hi, net_lo: req_q.dest_lo,
				gw_hi: req_q.gateway_hi, gw_lo: req_q.gateway_lo, prefix: len_c,
				iface: req_q.interface_index, metric: req_q.metric};
		end
	end

	genvar g;
	generate
		for (g = 0; g < ROUTE_ENTRIES; g++) begin : g_row
			if (g == ROUTE_ENTRIES - 1) begin : g_tail
				iplpr_cell u_cell (.clk, .arst_n, .shift(shift_c),
					.load(put_c && (int'(gap_q) == ROUTE_ENTRIES - 1 - g)),
					.load_route(put_route), .route_in('0), .use_in(1'b0),
					.route(cell_route[g]), .used(cell_used[g]));
			end else begin : g_mid
				iplpr_cell u_cell (.clk, .arst_n, .shift(shift_c),
					.load(put_c && (int'(gap_q) == ROUTE_ENTRIES - 1 - g)),
					.load_route(put_route), .route_in(cell_route[g+1]),
					.use_in(cell_used[g+1]),
					.route(cell_route[g]), .used(cell_used[g]));
			end
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (req.valid) state_d = S_SCAN;
			S_SCAN: if (last_c) state_d = S_DONE;
			S_DONE: if (!rsp_valid_q || rsp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = state_q == S_IDLE;
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q <= '0;
			count_q <= '0;
			gap_q <= '0;
			full_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			hit_q <= 1'b0;
			stop_q <= 1'b0;
			longest_q <= '0;
			shortest_q <= FULL_METRIC;
		end else begin
			state_q <= state_d;
			if (done_c) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
			if (state_q == S_IDLE && req.valid) begin
				step_q <= '0;
				gap_q <= '0;
				full_q <= {{(32-CW){1'b0}}, count_q} >= ROUTE_ENTRIES;
				hit_q <= 1'b0;
				stop_q <= 1'b0;
				longest_q <= '0;
				shortest_q <= FULL_METRIC;
			end
			if (state_q == S_SCAN) begin
				step_q <= step_q + 1'b1;
				if (!put_c) gap_q <= gap_q + 1'b1;
				if (cell_used[0] && drop_c) count_q <= count_q - 1'b1;
				else if (ins_put) count_q <= count_q + 1'b1;
				if (req_q.mode == OP_HAS_DEST) begin
					if (match_c && !stop_q && head.iface == req_q.interface_index) begin
						hit_q <= 1'b1;
						stop_q <= 1'b1;
					end
				end else if (take_c) begin
					longest_q <= head.prefix;
					shortest_q <= head.metric;
					hit_q <= 1'b1;
					if (head.prefix == HOST_PREFIX) stop_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && take_c && req_q.mode == OP_LOOKUP) begin
			pick_q <= head;
		end
	end

	always_comb begin
		rsp_d = '0;
		case (req_q.mode)
			OP_INSERT: begin
				if ({28'd0, req_q.interface_index} >= IFACE_COUNT)
					rsp_d.status = ST_NO_ROUTE;
				else if (full_q)
					rsp_d.status = ST_FULL;
			end
			OP_LOOKUP: begin
				if (is_mc) begin
					rsp_d.found = 1'b1;
					rsp_d.route_dest_hi = req_q.dest_hi;
					rsp_d.route_dest_lo = req_q.dest_lo;
					rsp_d.route_interface = req_q.filter_enable ?
						req_q.interface_index : 4'd0;
				end else if (hit_q) begin
					rsp_d.found = 1'b1;
					rsp_d.route_dest_hi = pick_q.net_hi;
					rsp_d.route_dest_lo = pick_q.net_lo;
					rsp_d.route_gateway_hi = pick_q.gw_hi;
					rsp_d.route_gateway_lo = pick_q.gw_lo;
					rsp_d.route_interface = pick_q.iface;
					rsp_d.route_metric = pick_q.metric;
				end else begin
					rsp_d.status = ST_NO_ROUTE;
				end
			end
			OP_HAS_DEST: begin
				rsp_d.found = hit_q;
				rsp_d.status = hit_q ? ST_OK : ST_NO_ROUTE;
			end
			default: rsp_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (done_c) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data = rsp_q;

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> req.ready) else $error("ready low in idle");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{{(32-CW){1'b0}}, count_q} <= ROUTE_ENTRIES) else $error("count overflow");
	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && $past(state_q) == S_SCAN) |-> step_q != '0)
		else $error("scan step wrapped");
endmodule
